### hw/rtl/tab_record_field_parser_unit_assert.svh
// Assertion helpers for the record field parser.
// Every check is clocked on i_clk and is switched off while i_rst_n is low.
`ifndef TAB_RECORD_FIELD_PARSER_UNIT_ASSERT_SVH
`define TAB_RECORD_FIELD_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication
`define TRFP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define TRFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/trfp_pkg.sv
`default_nettype none

package trfp_pkg;

    // Byte codes
    localparam logic [7:0] NUL_BYTE   = 8'h00;
    localparam logic [7:0] TAB_BYTE   = 8'h09;
    localparam logic [7:0] LF_BYTE    = 8'h0A;
    localparam logic [7:0] CR_BYTE    = 8'h0D;
    localparam logic [7:0] SPACE_BYTE = 8'h20;
    localparam logic [7:0] PLUS_BYTE  = 8'h2B;
    localparam logic [7:0] MINUS_BYTE = 8'h2D;
    localparam logic [7:0] ZERO_BYTE  = 8'h30;
    localparam logic [7:0] NINE_BYTE  = 8'h39;
    localparam logic [7:0] UPPER_X    = 8'h58;
    localparam logic [7:0] LOWER_X    = 8'h78;
    localparam logic [7:0] UPPER_Y    = 8'h59;
    localparam logic [7:0] LOWER_Y    = 8'h79;

    // Chromosome codes for the sex chromosomes
    localparam logic signed [31:0] CHROM_X = 32'sd23;
    localparam logic signed [31:0] CHROM_Y = 32'sd24;

    // Field numbers of interest
    localparam logic [3:0] FIELD_CHROM = 4'd0;
    localparam logic [3:0] FIELD_POS   = 4'd1;
    localparam logic [3:0] FIELD_REF   = 4'd3;
    localparam logic [3:0] FIELD_ALT   = 4'd4;
    localparam logic [3:0] FIELD_NAME  = 4'd8;
    localparam logic [3:0] FIELD_MAX   = 4'd15;

    // Number conversion phases (code 3 behaves as done)
    localparam logic [1:0] PH_SKIP   = 2'd0;
    localparam logic [1:0] PH_DIGITS = 2'd1;
    localparam logic [1:0] PH_DONE   = 2'd2;

    // Result kinds
    localparam logic KIND_NAME    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Result queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Saturation limits on the widened sum
    localparam logic signed [35:0] SAT_HI = 36'sd2147483647;
    localparam logic signed [35:0] SAT_LO = -36'sd2147483648;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       line_last;
    } t_in_item;

    typedef struct packed {
        logic              item_kind;
        logic [7:0]        name_byte;
        logic signed [31:0] chromosome;
        logic signed [31:0] position;
        logic [7:0]        ref_base;
        logic [7:0]        alt_base;
        logic              record_done;
    } t_out_item;

    typedef struct packed {
        logic signed [31:0] value;
        logic [1:0]         phase;
        logic               neg;
    } t_dec;

    // v * 10 +/- d, saturated to 32 bits
    function automatic logic signed [31:0] times_ten_plus(
        input logic signed [31:0] v,
        input logic               neg,
        input logic [3:0]         d
    );
        logic signed [35:0] w;
        logic signed [35:0] t;
        logic signed [35:0] dw;
        begin
            w  = {{4{v[31]}}, v};
            dw = $signed({32'd0, d});
            t  = (w <<< 3) + (w <<< 1);
            t  = neg ? (t - dw) : (t + dw);
            if (t > SAT_HI) begin
                times_ten_plus = 32'sh7FFF_FFFF;
            end else if (t < SAT_LO) begin
                times_ten_plus = 32'sh8000_0000;
            end else begin
                times_ten_plus = t[31:0];
            end
        end
    endfunction

    // One byte of atoi-style conversion
    function automatic t_dec decimal_step(input t_dec s, input logic [7:0] b);
        t_dec r;
        logic dig;
        logic blank;
        begin
            r     = s;
            dig   = (b >= ZERO_BYTE) && (b <= NINE_BYTE);
            blank = (b == SPACE_BYTE) || ((b >= LF_BYTE) && (b <= CR_BYTE));
            if (s.phase == PH_SKIP) begin
                if (blank) begin
                    r = s;
                end else if (b == PLUS_BYTE) begin
                    r.phase = PH_DIGITS;
                end else if (b == MINUS_BYTE) begin
                    r.phase = PH_DIGITS;
                    r.neg   = 1'b1;
                end else if (dig) begin
                    r.phase = PH_DIGITS;
                    r.value = times_ten_plus(s.value, s.neg, b[3:0]);
                end else begin
                    r.phase = PH_DONE;
                end
            end else if (s.phase == PH_DIGITS) begin
                if (dig) begin
                    r.value = times_ten_plus(s.value, s.neg, b[3:0]);
                end else begin
                    r.phase = PH_DONE;
                end
            end
            decimal_step = r;
        end
    endfunction

endpackage

`default_nettype wire

### hw/rtl/tab_record_field_parser_unit.sv
// Record field parser: takes one byte of a tab-separated variant record per
// request and returns the sample-name bytes of field 8 as they arrive, then a
// summary (chromosome, position, first REF and ALT bytes) after the byte
// flagged line_last. Bytes are taken one per cycle while the result queue has
// room; each is held in an input register, parsed and its results pushed into
// a four-entry result queue. The output side delivers one result per cycle
// while the receiver is ready, so the sustained rate is one byte per cycle,
// except that a final byte that is also a name byte yields two results and
// takes an extra output slot. A NUL byte ends the record text early; the
// summary still follows the flagged byte, after which all state is cleared.
`default_nettype none

module tab_record_field_parser_unit (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  trfp_pkg::t_in_item    i_in_data,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output trfp_pkg::t_out_item   o_out_data
);

    localparam int QPTR_W = trfp_pkg::QPTR_W;
    localparam int QCNT_W = trfp_pkg::QCNT_W;

    // Input register
    logic               r_in_valid;
    trfp_pkg::t_in_item r_in;

    // Parser state
    logic [3:0]         r_field;
    logic               r_at_start;
    logic [1:0]         r_phase;
    logic               r_neg;
    logic signed [31:0] r_chrom;
    logic signed [31:0] r_pos;
    logic [7:0]         r_ref;
    logic [7:0]         r_alt;
    logic               r_ended;

    logic [3:0]         n_field;
    logic               n_at_start;
    logic [1:0]         n_phase;
    logic               n_neg;
    logic signed [31:0] n_chrom;
    logic signed [31:0] n_pos;
    logic [7:0]         n_ref;
    logic [7:0]         n_alt;
    logic               n_ended;

    // Result queue
    trfp_pkg::t_out_item r_queue [trfp_pkg::QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;

    logic                fire;
    logic                pop;
    logic [1:0]          n_push;
    logic                name_hit;
    trfp_pkg::t_out_item res0;
    trfp_pkg::t_out_item res1;
    trfp_pkg::t_out_item name_item;
    trfp_pkg::t_out_item sum_item;
    trfp_pkg::t_dec      dec_in;
    trfp_pkg::t_dec      dec_out;
    logic [7:0]          b;

    // Handshake
    assign pop         = o_out_valid && i_out_ready;
    assign o_out_valid = (r_count != '0);
    assign o_out_data  = r_queue[r_rd_ptr];
    assign fire        = r_in_valid &&
                         ((r_count - QCNT_W'(pop)) <= QCNT_W'(trfp_pkg::QUEUE_DEPTH - 2));
    assign o_in_ready  = !r_in_valid || fire;
    assign b           = r_in.text_byte;

    // Shared decimal converter, fed from the field being read
    always_comb begin
        dec_in.value = (r_field == trfp_pkg::FIELD_CHROM) ? r_chrom : r_pos;
        dec_in.phase = r_phase;
        dec_in.neg   = r_neg;
        dec_out      = trfp_pkg::decimal_step(dec_in, b);
    end

    // Per-byte parse
    always_comb begin
        n_field    = r_field;
        n_at_start = r_at_start;
        n_phase    = r_phase;
        n_neg      = r_neg;
        n_chrom    = r_chrom;
        n_pos      = r_pos;
        n_ref      = r_ref;
        n_alt      = r_alt;
        n_ended    = r_ended;
        name_hit   = 1'b0;
        if (!r_ended) begin
            if (b == trfp_pkg::NUL_BYTE) begin
                n_ended = 1'b1;
            end else if (b == trfp_pkg::TAB_BYTE) begin
                if (r_at_start && r_field == trfp_pkg::FIELD_REF) begin
                    n_ref = trfp_pkg::TAB_BYTE;
                end
                if (r_at_start && r_field == trfp_pkg::FIELD_ALT) begin
                    n_alt = trfp_pkg::TAB_BYTE;
                end
                if (r_field != trfp_pkg::FIELD_MAX) begin
                    n_field = r_field + 4'd1;
                end
                n_at_start = 1'b1;
                n_phase    = trfp_pkg::PH_SKIP;
                n_neg      = 1'b0;
            end else begin
                if (r_field == trfp_pkg::FIELD_CHROM) begin
                    if (r_at_start && (b == trfp_pkg::UPPER_X || b == trfp_pkg::LOWER_X)) begin
                        n_chrom = trfp_pkg::CHROM_X;
                        n_phase = trfp_pkg::PH_DONE;
                    end else if (r_at_start &&
                                 (b == trfp_pkg::UPPER_Y || b == trfp_pkg::LOWER_Y)) begin
                        n_chrom = trfp_pkg::CHROM_Y;
                        n_phase = trfp_pkg::PH_DONE;
                    end else begin
                        n_chrom = dec_out.value;
                        n_phase = dec_out.phase;
                        n_neg   = dec_out.neg;
                    end
                end else if (r_field == trfp_pkg::FIELD_POS) begin
                    n_pos   = dec_out.value;
                    n_phase = dec_out.phase;
                    n_neg   = dec_out.neg;
                end else if (r_field == trfp_pkg::FIELD_REF && r_at_start) begin
                    n_ref = b;
                end else if (r_field == trfp_pkg::FIELD_ALT && r_at_start) begin
                    n_alt = b;
                end else if (r_field == trfp_pkg::FIELD_NAME) begin
                    name_hit = 1'b1;
                end
                n_at_start = 1'b0;
            end
        end
    end

    // Result assembly: name byte first, summary second
    always_comb begin
        name_item             = '0;
        name_item.item_kind   = trfp_pkg::KIND_NAME;
        name_item.name_byte   = b;

        sum_item              = '0;
        sum_item.item_kind    = trfp_pkg::KIND_SUMMARY;
        sum_item.chromosome   = n_chrom;
        sum_item.position     = n_pos;
        sum_item.ref_base     = n_ref;
        sum_item.alt_base     = n_alt;
        sum_item.record_done  = 1'b1;

        res0   = name_hit ? name_item : sum_item;
        res1   = sum_item;
        n_push = 2'(name_hit) + 2'(r_in.line_last);
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // Parser state, cleared after every summary
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (fire && r_in.line_last)) begin
            r_field    <= '0;
            r_at_start <= 1'b1;
            r_phase    <= trfp_pkg::PH_SKIP;
            r_neg      <= 1'b0;
            r_chrom    <= '0;
            r_pos      <= '0;
            r_ref      <= '0;
            r_alt      <= '0;
            r_ended    <= 1'b0;
        end else if (fire) begin
            r_field    <= n_field;
            r_at_start <= n_at_start;
            r_phase    <= n_phase;
            r_neg      <= n_neg;
            r_chrom    <= n_chrom;
            r_pos      <= n_pos;
            r_ref      <= n_ref;
            r_alt      <= n_alt;
            r_ended    <= n_ended;
        end
    end

    // Result queue storage
    always_ff @(posedge i_clk) begin
        if (fire && n_push != 2'd0) begin
            r_queue[r_wr_ptr] <= res0;
        end
        if (fire && n_push == 2'd2) begin
            r_queue[r_wr_ptr + QPTR_W'(1)] <= res1;
        end
    end

    // Result queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (fire) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(n_push);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= r_count + (fire ? QCNT_W'(n_push) : QCNT_W'(0)) - QCNT_W'(pop);
        end
    end

`include "tab_record_field_parser_unit_assert.svh"

    `TRFP_ASSERT_NOW(a_queue_bound, 1'b1, r_count <= QCNT_W'(trfp_pkg::QUEUE_DEPTH), "result queue overfilled")
    `TRFP_ASSERT_NEXT(a_count_track, 1'b1, r_count == $past(r_count) + (($past(fire)) ? QCNT_W'($past(n_push)) : QCNT_W'(0)) - QCNT_W'($past(pop)), "queue count drifted")
    `TRFP_ASSERT_NEXT(a_clear_after_sum, fire && r_in.line_last, r_field == '0 && r_at_start && !r_ended, "state not cleared after summary")
    `TRFP_ASSERT_NOW(a_summary_marked, o_out_valid && o_out_data.item_kind == trfp_pkg::KIND_SUMMARY, o_out_data.record_done, "summary without record_done")
    `TRFP_ASSERT_NOW(a_name_in_field, fire && name_hit, r_field == trfp_pkg::FIELD_NAME && !r_ended, "name byte outside sample field")

endmodule

`default_nettype wire

### tb/trfp_record_checker.sv
`timescale 1ns / 100ps

module trfp_record_checker (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  wire                 i_in_ready,
    input  trfp_pkg::t_in_item  i_in_data,
    input  wire                 i_out_valid,
    input  wire                 i_out_ready,
    input  trfp_pkg::t_out_item i_out_data,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_checked
);

    localparam longint SAT_TOP = 64'sd2147483647;
    localparam longint SAT_BOT = -64'sd2147483648;

    // Parser state as seen from the byte stream
    logic [3:0]         field_idx;
    logic               field_fresh;
    logic [1:0]         conv_phase;
    logic               conv_neg;
    logic signed [31:0] chrom_acc;
    logic signed [31:0] pos_acc;
    logic [7:0]         ref_first;
    logic [7:0]         alt_first;
    logic               text_cut;

    // Results owed by the parser, oldest first
    trfp_pkg::t_out_item parsed_results[$];

    int fail_total    = 0;
    int checked_total = 0;
    int owed_total    = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = owed_total;
    assign o_checked    = checked_total;

    task automatic report_mismatch(input string msg);
        fail_total++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string label, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d, %s: got %0h, expected %0h",
                                      checked_total, label, got, want));
        end
    endtask

    // Append one owed result at the tail
    task automatic owe_result(input trfp_pkg::t_out_item res);
        parsed_results = {parsed_results, res};
    endtask

    task automatic clear_record();
        field_idx   = trfp_pkg::FIELD_CHROM;
        field_fresh = 1'b1;
        conv_phase  = trfp_pkg::PH_SKIP;
        conv_neg    = 1'b0;
        chrom_acc   = '0;
        pos_acc     = '0;
        ref_first   = '0;
        alt_first   = '0;
        text_cut    = 1'b0;
    endtask

    // acc * 10 +/- digit, clamped to the signed 32-bit range
    function automatic logic signed [31:0] scale_in_digit(input logic signed [31:0] acc,
                                                         input logic minus,
                                                         input logic [7:0] ch);
        longint wide;
        longint digit;
        digit = ch - trfp_pkg::ZERO_BYTE;
        wide  = longint'(acc) * 10;
        wide  = minus ? wide - digit : wide + digit;
        if (wide > SAT_TOP) begin
            wide = SAT_TOP;
        end else if (wide < SAT_BOT) begin
            wide = SAT_BOT;
        end
        return wide[31:0];
    endfunction

    // atoi-like conversion, one byte at a time; phase 3 behaves as done
    task automatic step_number(inout logic signed [31:0] acc, input logic [7:0] ch);
        logic is_digit;
        logic blank;
        is_digit = (ch >= trfp_pkg::ZERO_BYTE) && (ch <= trfp_pkg::NINE_BYTE);
        blank    = (ch == trfp_pkg::SPACE_BYTE) ||
                   ((ch >= trfp_pkg::LF_BYTE) && (ch <= trfp_pkg::CR_BYTE));
        if (conv_phase == trfp_pkg::PH_SKIP) begin
            if (ch == trfp_pkg::PLUS_BYTE) begin
                conv_phase = trfp_pkg::PH_DIGITS;
            end else if (ch == trfp_pkg::MINUS_BYTE) begin
                conv_phase = trfp_pkg::PH_DIGITS;
                conv_neg   = 1'b1;
            end else if (is_digit) begin
                conv_phase = trfp_pkg::PH_DIGITS;
                acc        = scale_in_digit(acc, conv_neg, ch);
            end else if (!blank) begin
                conv_phase = trfp_pkg::PH_DONE;
            end
        end else if (conv_phase == trfp_pkg::PH_DIGITS) begin
            if (is_digit) begin
                acc = scale_in_digit(acc, conv_neg, ch);
            end else begin
                conv_phase = trfp_pkg::PH_DONE;
            end
        end
    endtask

    // Work out what one accepted request owes
    task automatic parse_byte(input trfp_pkg::t_in_item req);
        trfp_pkg::t_out_item res;
        logic [7:0]          ch;
        ch = req.text_byte;
        if (!text_cut) begin
            if (ch == trfp_pkg::NUL_BYTE) begin
                text_cut = 1'b1;
            end else if (ch == trfp_pkg::TAB_BYTE) begin
                if (field_fresh && field_idx == trfp_pkg::FIELD_REF)
                    ref_first = trfp_pkg::TAB_BYTE;
                if (field_fresh && field_idx == trfp_pkg::FIELD_ALT)
                    alt_first = trfp_pkg::TAB_BYTE;
                if (field_idx != trfp_pkg::FIELD_MAX) field_idx = field_idx + 4'd1;
                field_fresh = 1'b1;
                conv_phase  = trfp_pkg::PH_SKIP;
                conv_neg    = 1'b0;
            end else begin
                case (field_idx)
                    trfp_pkg::FIELD_CHROM: begin
                        if (field_fresh &&
                            (ch == trfp_pkg::UPPER_X || ch == trfp_pkg::LOWER_X)) begin
                            chrom_acc  = trfp_pkg::CHROM_X;
                            conv_phase = trfp_pkg::PH_DONE;
                        end else if (field_fresh &&
                                     (ch == trfp_pkg::UPPER_Y || ch == trfp_pkg::LOWER_Y)) begin
                            chrom_acc  = trfp_pkg::CHROM_Y;
                            conv_phase = trfp_pkg::PH_DONE;
                        end else begin
                            step_number(chrom_acc, ch);
                        end
                    end
                    trfp_pkg::FIELD_POS: begin
                        step_number(pos_acc, ch);
                    end
                    trfp_pkg::FIELD_REF: begin
                        if (field_fresh) ref_first = ch;
                    end
                    trfp_pkg::FIELD_ALT: begin
                        if (field_fresh) alt_first = ch;
                    end
                    trfp_pkg::FIELD_NAME: begin
                        res           = '0;
                        res.item_kind = trfp_pkg::KIND_NAME;
                        res.name_byte = ch;
                        owe_result(res);
                    end
                    default: ;
                endcase
                field_fresh = 1'b0;
            end
        end
        // summary closes the record and clears everything
        if (req.line_last) begin
            res             = '0;
            res.item_kind   = trfp_pkg::KIND_SUMMARY;
            res.chromosome  = chrom_acc;
            res.position    = pos_acc;
            res.ref_base    = ref_first;
            res.alt_base    = alt_first;
            res.record_done = 1'b1;
            owe_result(res);
            clear_record();
        end
    endtask

    // Watch both channels
    always @(posedge i_clk) begin
        trfp_pkg::t_out_item want;
        if (!i_rst_n) begin
            clear_record();
            parsed_results.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                parse_byte(i_in_data);
            end
            if (i_out_valid && i_out_ready) begin
                if (parsed_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing owed",
                                              checked_total));
                end else begin
                    want = parsed_results.pop_front();
                    check_field("item_kind", i_out_data.item_kind, want.item_kind);
                    check_field("name_byte", i_out_data.name_byte, want.name_byte);
                    check_field("chromosome", i_out_data.chromosome, want.chromosome);
                    check_field("position", i_out_data.position, want.position);
                    check_field("ref_base", i_out_data.ref_base, want.ref_base);
                    check_field("alt_base", i_out_data.alt_base, want.alt_base);
                    check_field("record_done", i_out_data.record_done, want.record_done);
                end
                checked_total++;
            end
        end
        owed_total <= parsed_results.size();
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int ITEM_COUNT  = 1600;
    localparam int CALM_ITEMS  = 150;
    localparam int QUIET_LIMIT = 4000;
    localparam int TAIL_CYCLES = 8;

    typedef enum logic [1:0] {IDLE_OFF, IDLE_LIGHT, IDLE_HEAVY} t_idle;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    trfp_pkg::t_in_item  in_data   = '0;
    logic                out_ready = 1'b0;
    logic                in_ready;
    logic                out_valid;
    trfp_pkg::t_out_item out_data;

    int fail_count;
    int pending;
    int checked;

    t_idle      idle_mode    = IDLE_OFF;
    int         ready_hold   = 0;
    int         quiet        = 0;
    int         bytes_sent   = 0;
    int         records_sent = 0;
    logic [7:0] rec[$];
    logic [7:0] bases[5]     = '{"A", "C", "G", "T", "N"};

    tab_record_field_parser_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    trfp_record_checker rec_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    function automatic bit idle_now();
        case (idle_mode)
            IDLE_LIGHT: return $urandom_range(0, 7) == 0;
            IDLE_HEAVY: return $urandom_range(0, 2) == 0;
            default:    return 1'b0;
        endcase
    endfunction

    // Receiver back-pressure in random bursts
    always @(posedge clk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            out_ready  <= 1'b0;
        end else if (idle_now()) begin
            ready_hold <= $urandom_range(0, 8);
            out_ready  <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Give up when nothing moves for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet <= 0;
        end else if (quiet == QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // Append one byte to the record being built
    task automatic append_byte(input logic [7:0] ch);
        rec = {rec, ch};
    endtask

    // any byte but NUL and tab
    function automatic logic [7:0] text_char();
        logic [7:0] ch;
        do begin
            ch = 8'($urandom_range(1, 255));
        end while (ch == trfp_pkg::TAB_BYTE);
        return ch;
    endfunction

    task automatic add_decimal(input int digits);
        int k;
        if ($urandom_range(0, 5) == 0) begin
            append_byte($urandom_range(0, 1) ? trfp_pkg::SPACE_BYTE
                        : 8'($urandom_range(trfp_pkg::LF_BYTE, trfp_pkg::CR_BYTE)));
        end
        case ($urandom_range(0, 3))
            0:       append_byte(trfp_pkg::MINUS_BYTE);
            1:       append_byte(trfp_pkg::PLUS_BYTE);
            default: ;
        endcase
        for (k = 0; k < digits; k++) begin
            append_byte(8'(trfp_pkg::ZERO_BYTE + $urandom_range(0, 9)));
        end
        // trailing junk, which ends the number unless it is a digit
        if ($urandom_range(0, 5) == 0) append_byte(text_char());
    endtask

    task automatic add_text(input int len);
        repeat (len) append_byte(text_char());
        append_byte(trfp_pkg::TAB_BYTE);
    endtask

    task automatic add_bases();
        repeat ($urandom_range(0, 3)) append_byte(bases[$urandom_range(0, 4)]);
        append_byte(trfp_pkg::TAB_BYTE);
    endtask

    // A plausible variant line, sometimes cut short, overlong or NUL-broken
    task automatic build_wellformed();
        int cut;
        rec.delete();
        case ($urandom_range(0, 5))
            0:       append_byte($urandom_range(0, 1) ? trfp_pkg::UPPER_X : trfp_pkg::LOWER_X);
            1:       append_byte($urandom_range(0, 1) ? trfp_pkg::UPPER_Y : trfp_pkg::LOWER_Y);
            default: add_decimal($urandom_range(0, 9) == 0 ? 11 : $urandom_range(1, 2));
        endcase
        append_byte(trfp_pkg::TAB_BYTE);
        add_decimal($urandom_range(0, 3) == 0 ? $urandom_range(10, 13)
                                              : $urandom_range(0, 9));
        append_byte(trfp_pkg::TAB_BYTE);
        add_text($urandom_range(0, 2));
        add_bases();
        add_bases();
        repeat (3) add_text($urandom_range(0, 2));
        repeat ($urandom_range(1, 6)) append_byte(text_char());
        if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 10)) begin
                append_byte(trfp_pkg::TAB_BYTE);
                append_byte(text_char());
            end
        end
        if ($urandom_range(0, 4) == 0) begin
            cut = $urandom_range(1, rec.size());
            while (rec.size() > cut) void'(rec.pop_back());
        end
        if ($urandom_range(0, 7) == 0)
            rec[$urandom_range(0, rec.size() - 1)] = trfp_pkg::NUL_BYTE;
    endtask

    task automatic build_noise();
        rec.delete();
        repeat ($urandom_range(1, 30)) begin
            case ($urandom_range(0, 15))
                0, 1, 2, 3: append_byte(trfp_pkg::TAB_BYTE);
                4:          append_byte(trfp_pkg::NUL_BYTE);
                default:    append_byte(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    // One request per byte; valid held until accepted
    task automatic send_byte(input logic [7:0] ch, input logic last);
        if (idle_now()) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid          <= 1'b1;
        in_data.text_byte <= ch;
        in_data.line_last <= last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_record();
        int k;
        for (k = 0; k < rec.size(); k++) begin
            send_byte(rec[k], k == rec.size() - 1);
        end
        records_sent++;
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idle_mode <= IDLE_LIGHT;

        // empty record: lone NUL on the last byte
        rec = '{trfp_pkg::NUL_BYTE};
        send_record();
        // X chromosome, signed position, empty REF
        rec = '{trfp_pkg::UPPER_X, trfp_pkg::TAB_BYTE, trfp_pkg::PLUS_BYTE, "1", "2",
                trfp_pkg::TAB_BYTE, trfp_pkg::TAB_BYTE, trfp_pkg::TAB_BYTE, "G"};
        send_record();
        // lower-case y, blank position, ALT missing, bytes after NUL ignored
        rec = '{trfp_pkg::LOWER_Y, trfp_pkg::TAB_BYTE, trfp_pkg::SPACE_BYTE,
                trfp_pkg::TAB_BYTE, ".", trfp_pkg::TAB_BYTE, "C", trfp_pkg::NUL_BYTE, "Z"};
        send_record();
        // negative chromosome, sample name on the final byte
        rec = '{trfp_pkg::MINUS_BYTE, "9", trfp_pkg::TAB_BYTE, trfp_pkg::TAB_BYTE,
                trfp_pkg::TAB_BYTE, trfp_pkg::TAB_BYTE, trfp_pkg::TAB_BYTE,
                trfp_pkg::TAB_BYTE, trfp_pkg::TAB_BYTE, trfp_pkg::TAB_BYTE, "S"};
        send_record();

        // random records with varying back-pressure
        while (bytes_sent < ITEM_COUNT - CALM_ITEMS) begin
            idle_mode <= t_idle'($urandom_range(0, 2));
            if ($urandom_range(0, 9) < 3) begin
                build_noise();
            end else begin
                build_wellformed();
            end
            send_record();
        end

        // closing stretch at full rate
        idle_mode <= IDLE_OFF;
        while (bytes_sent < ITEM_COUNT) begin
            build_wellformed();
            send_record();
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d records (%0d bytes), %0d results compared.",
                 records_sent, bytes_sent, checked);
        $display("Mix: X/Y and decimal chromosomes, saturating positions, NUL cut-offs, noise.");
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
